[sv/key_merge_press_counter_assert.svh]
// Assertion macros, clocked on clk, disabled in reset.
`ifndef KEY_MERGE_PRESS_COUNTER_ASSERT_SVH
`define KEY_MERGE_PRESS_COUNTER_ASSERT_SVH

// cons holds in the same cycle as ante
`define KMPC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// cons holds in the cycle after ante
`define KMPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/kmpc_pkg.sv]
package kmpc_pkg;

  localparam int MAP_PAIRS        = 6;
  localparam int REGISTRY_ENTRIES = 8;

  localparam int POS_W  = 8;
  localparam int CNT_W  = 8;
  localparam int PC_W   = 3;
  localparam int WORD_W = 16;
  localparam int CIDX_W = 3;

  localparam int PAIR_W = (MAP_PAIRS > 1) ? $clog2(MAP_PAIRS) : 1;
  localparam int ENT_W  = (REGISTRY_ENTRIES > 1) ? $clog2(REGISTRY_ENTRIES) : 1;
  localparam int SCAN_W = $clog2(REGISTRY_ENTRIES + 1);

  localparam logic [CNT_W-1:0] COUNT_MAX = 8'hFF;

  // register indexes
  localparam logic [CIDX_W-1:0] REG_PAIR_COUNT = 3'd0;
  localparam logic [CIDX_W-1:0] REG_PAIR_WORD0 = 3'd1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MAP  = 4'b0010,
    S_SCAN = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [CNT_W-1:0] cnt;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

[sv/kmpc_ram.sv]
module kmpc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/key_merge_press_counter.sv]
// channel | signals                              | direction
// --------+--------------------------------------+----------
// in      | in_valid/in_ready, key_position,     | in
//         | is_press                             |
// out     | out_valid/out_ready, consumed,       | out
//         | mapped_position, registry_overflow   |
// cfg     | cfg_valid/cfg_ready, cfg_index,      | in
//         | cfg_data                             |
//
// One word in flight. Each accepted key walks the pairs in use; a related key
// then scans the registry, reading one entry a cycle from the position/count
// RAM, and an unrelated key goes straight to the result.
// Reset clears config, entry valid bits and control; RAM contents are unused
// until written. A stalled result waits in the output register while the
// next word is accepted; the update then waits for the register to free up.
module key_merge_press_counter (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [kmpc_pkg::POS_W-1:0]    key_position,
  input  logic                          is_press,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          consumed,
  output logic [kmpc_pkg::POS_W-1:0]    mapped_position,
  output logic                          registry_overflow,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [kmpc_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [kmpc_pkg::WORD_W-1:0]   cfg_data
);

  localparam int ENTRIES = kmpc_pkg::REGISTRY_ENTRIES;
  localparam int ENT_W   = kmpc_pkg::ENT_W;
  localparam int SCAN_W  = kmpc_pkg::SCAN_W;
  localparam int POS_W   = kmpc_pkg::POS_W;
  localparam int CNT_W   = kmpc_pkg::CNT_W;
  localparam int PC_W    = kmpc_pkg::PC_W;
  localparam int PAIR_W  = kmpc_pkg::PAIR_W;

  kmpc_pkg::state_t state;

  logic [PC_W-1:0]   pair_count;
  logic [kmpc_pkg::WORD_W-1:0] pair_word [kmpc_pkg::MAP_PAIRS];

  logic [POS_W-1:0]  pos;
  logic              press;
  logic              related;
  logic [PC_W-1:0]   pidx;
  logic [PC_W-1:0]   used;
  logic [SCAN_W-1:0] sidx;
  logic [ENT_W-1:0]  chk_idx;
  logic              chk_vld;
  logic              hit_found;
  logic [ENT_W-1:0]  hit_idx;
  logic [CNT_W-1:0]  hit_cnt;
  logic              free_found;
  logic [ENT_W-1:0]  free_idx;
  logic [ENTRIES-1:0] entry_valid;

  logic [PC_W-1:0]   used_lim;
  logic [kmpc_pkg::WORD_W-1:0] cur_pair;
  logic [POS_W-1:0]  pair_from;
  logic [POS_W-1:0]  pair_to;
  logic              cfg_fire;
  logic [3:0]        cfg_idx_ext;
  logic [PAIR_W-1:0] cfg_pair;
  kmpc_pkg::entry_t  rd_entry;
  kmpc_pkg::entry_t  wr_entry;
  logic              ram_we;
  logic [ENT_W-1:0]  ram_waddr;
  logic              scan_match;
  logic              scan_free;
  logic              scan_last;
  logic              out_free;
  logic              done_fire;
  logic [CNT_W-1:0]  cnt_next;
  logic              do_hit;
  logic              do_alloc;
  logic              do_overflow;

  assign in_ready  = (state == kmpc_pkg::S_IDLE);
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign cfg_idx_ext = {1'b0, cfg_index};
  assign cfg_pair  = PAIR_W'(cfg_index - kmpc_pkg::REG_PAIR_WORD0);

  assign used_lim = (pair_count > PC_W'(kmpc_pkg::MAP_PAIRS)) ?
                    PC_W'(kmpc_pkg::MAP_PAIRS) : pair_count;

  assign cur_pair  = pair_word[pidx[PAIR_W-1:0]];
  assign pair_from = cur_pair[15:8];
  assign pair_to   = cur_pair[7:0];

  assign scan_match = chk_vld && entry_valid[chk_idx] && (rd_entry.pos == pos);
  assign scan_free  = chk_vld && !entry_valid[chk_idx];
  assign scan_last  = chk_vld && (chk_idx == ENT_W'(ENTRIES - 1));

  assign out_free  = !out_valid || out_ready;
  assign done_fire = (state == kmpc_pkg::S_DONE) && out_free;

  always_comb begin
    if (press) begin
      cnt_next = (hit_cnt == kmpc_pkg::COUNT_MAX) ? hit_cnt : hit_cnt + 1'b1;
    end else begin
      cnt_next = (hit_cnt != '0) ? hit_cnt - 1'b1 : hit_cnt;
    end
  end

  assign do_hit      = related && hit_found;
  assign do_alloc    = related && !hit_found && press && free_found;
  assign do_overflow = related && !hit_found && press && !free_found;

  assign ram_we    = done_fire && ((do_hit && (cnt_next != '0)) || do_alloc);
  assign ram_waddr = hit_found ? hit_idx : free_idx;
  assign wr_entry.pos = pos;
  assign wr_entry.cnt = hit_found ? cnt_next : CNT_W'(1);

  kmpc_ram #(
    .WIDTH(kmpc_pkg::ENTRY_W),
    .DEPTH(ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(wr_entry),
    .raddr(sidx[ENT_W-1:0]),
    .rdata(rd_entry)
  );

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pair_count <= '0;
      for (int i = 0; i < kmpc_pkg::MAP_PAIRS; i++) begin
        pair_word[i] <= '0;
      end
    end else if (cfg_fire) begin
      if (cfg_index == kmpc_pkg::REG_PAIR_COUNT) begin
        pair_count <= cfg_data[PC_W-1:0];
      end else if (cfg_idx_ext <
                   4'(int'(kmpc_pkg::REG_PAIR_WORD0) + kmpc_pkg::MAP_PAIRS)) begin
        pair_word[cfg_pair] <= cfg_data;
      end
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= kmpc_pkg::S_IDLE;
      out_valid   <= 1'b0;
      entry_valid <= '0;
      chk_vld     <= 1'b0;
      hit_found   <= 1'b0;
      free_found  <= 1'b0;
      related     <= 1'b0;
    end else begin
      if (done_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        kmpc_pkg::S_IDLE: begin
          if (in_valid) begin
            related <= 1'b0;
            pidx    <= '0;
            used    <= used_lim;
            state   <= kmpc_pkg::S_MAP;
          end
        end
        kmpc_pkg::S_MAP: begin
          if (pidx == used) begin
            sidx       <= '0;
            chk_vld    <= 1'b0;
            hit_found  <= 1'b0;
            free_found <= 1'b0;
            state      <= related ? kmpc_pkg::S_SCAN : kmpc_pkg::S_DONE;
          end else begin
            if (pos == pair_to || pos == pair_from) begin
              related <= 1'b1;
            end
            pidx <= pidx + 1'b1;
          end
        end
        kmpc_pkg::S_SCAN: begin
          if (sidx != SCAN_W'(ENTRIES)) begin
            sidx    <= sidx + 1'b1;
            chk_vld <= 1'b1;
          end
          if (scan_match && !hit_found) begin
            hit_found <= 1'b1;
          end
          if (scan_free && !free_found) begin
            free_found <= 1'b1;
          end
          if (scan_last) begin
            state <= kmpc_pkg::S_DONE;
          end
        end
        kmpc_pkg::S_DONE: begin
          if (out_free) begin
            if (do_hit && (cnt_next == '0)) begin
              entry_valid[hit_idx] <= 1'b0;
            end
            if (do_alloc) begin
              entry_valid[free_idx] <= 1'b1;
            end
            state <= kmpc_pkg::S_IDLE;
          end
        end
        default: state <= kmpc_pkg::S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (state == kmpc_pkg::S_IDLE && in_valid) begin
      pos   <= key_position;
      press <= is_press;
    end
    if (state == kmpc_pkg::S_MAP && pidx != used && pos == pair_from) begin
      pos <= pair_to;
    end
    if (state == kmpc_pkg::S_SCAN) begin
      if (sidx != SCAN_W'(ENTRIES)) begin
        chk_idx <= sidx[ENT_W-1:0];
      end
      if (scan_match && !hit_found) begin
        hit_idx <= chk_idx;
        hit_cnt <= rd_entry.cnt;
      end
      if (scan_free && !free_found) begin
        free_idx <= chk_idx;
      end
    end
    if (done_fire) begin
      consumed          <= do_hit && (cnt_next != '0);
      mapped_position   <= pos;
      registry_overflow <= do_overflow;
    end
  end

`include "key_merge_press_counter_assert.svh"

  `KMPC_ASSERT_NEXT(a_one_word, in_valid && in_ready, !in_ready, "second word accepted")
  `KMPC_ASSERT_SAME(a_ovf_full, done_fire && do_overflow, &entry_valid, "overflow w/ free entry")
  `KMPC_ASSERT_SAME(a_hit_valid, done_fire && do_hit, entry_valid[hit_idx], "hit on free entry")
  `KMPC_ASSERT_SAME(a_ovf_pass, out_valid, !(consumed && registry_overflow), "overflow consumed")

endmodule

[tb/sv/key_merge_press_counter_tb.sv]
module key_merge_press_counter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAP_PAIRS        = kmpc_pkg::MAP_PAIRS;
  localparam int REGISTRY_ENTRIES = kmpc_pkg::REGISTRY_ENTRIES;
  localparam int POS_W            = kmpc_pkg::POS_W;
  localparam int CNT_W            = kmpc_pkg::CNT_W;
  localparam int PC_W             = kmpc_pkg::PC_W;
  localparam int WORD_W           = kmpc_pkg::WORD_W;
  localparam int CIDX_W           = kmpc_pkg::CIDX_W;
  localparam logic [CNT_W-1:0]  COUNT_MAX      = kmpc_pkg::COUNT_MAX;
  localparam logic [CIDX_W-1:0] REG_PAIR_COUNT = kmpc_pkg::REG_PAIR_COUNT;
  localparam logic [CIDX_W-1:0] REG_PAIR_WORD0 = kmpc_pkg::REG_PAIR_WORD0;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = REGISTRY_ENTRIES + MAP_PAIRS + 8;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic             press;
  } key_event_t;

  typedef struct packed {
    logic             consumed;
    logic [POS_W-1:0] merged;
    logic             overflow;
  } key_report_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  logic [POS_W-1:0] key_position = '0;
  logic is_press = 0;
  logic out_valid;
  logic out_ready = 0;
  logic consumed;
  logic [POS_W-1:0] mapped_position;
  logic registry_overflow;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [CIDX_W-1:0] cfg_index = '0;
  logic [WORD_W-1:0] cfg_data = '0;

  // predictor copy of config and registry
  logic [PC_W-1:0]   pairs_in_use = '0;
  logic [WORD_W-1:0] pair_map [MAP_PAIRS];
  logic              held [REGISTRY_ENTRIES];
  logic [POS_W-1:0]  held_pos [REGISTRY_ENTRIES];
  logic [CNT_W-1:0]  held_count [REGISTRY_ENTRIES];

  key_event_t  key_events [$];
  key_report_t expected_reports [$];

  int unsigned cycles = 0;
  int unsigned bad_count = 0;
  int unsigned in_wait = 0;
  int unsigned out_hold = 0;
  bit calm_in = 0;
  bit calm_out = 0;

  key_merge_press_counter DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .key_position(key_position),
    .is_press(is_press),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .consumed(consumed),
    .mapped_position(mapped_position),
    .registry_overflow(registry_overflow),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int draw_pause(inout bit calm);
    if ($urandom_range(0, 39) == 0) calm = !calm;
    return calm ? 0 : int'($urandom_range(0, 18));
  endfunction

  function automatic key_report_t merge_and_count(key_event_t ev);
    key_report_t r;
    int used;
    int hit;
    int slot;
    logic related;
    logic [POS_W-1:0] p;
    p = ev.pos;
    related = 0;
    hit = -1;
    slot = -1;
    r.consumed = 0;
    r.overflow = 0;
    used = (int'(pairs_in_use) > MAP_PAIRS) ? MAP_PAIRS : int'(pairs_in_use);
    for (int i = 0; i < used; i++) begin
      if (p == pair_map[i][7:0]) related = 1;
      if (p == pair_map[i][15:8]) begin
        p = pair_map[i][7:0];
        related = 1;
      end
    end
    if (related) begin
      for (int i = 0; i < REGISTRY_ENTRIES; i++)
        if (hit < 0 && held[i] && held_pos[i] == p) hit = i;
      if (hit >= 0) begin
        if (ev.press) begin
          if (held_count[hit] != COUNT_MAX) held_count[hit]++;
        end else if (held_count[hit] != 0) begin
          held_count[hit]--;
        end
        if (held_count[hit] == 0) held[hit] = 0;
        else r.consumed = 1;
      end else if (ev.press) begin
        for (int i = 0; i < REGISTRY_ENTRIES; i++)
          if (slot < 0 && !held[i]) slot = i;
        if (slot >= 0) begin
          held[slot] = 1;
          held_pos[slot] = p;
          held_count[slot] = 1;
        end else begin
          r.overflow = 1;
        end
      end
    end
    r.merged = p;
    return r;
  endfunction

  // input side
  always @(posedge clk) begin
    key_event_t ev;
    key_event_t taken;
    if (rst) begin
      in_valid <= 0;
      in_wait <= 0;
    end else begin
      if (in_valid && in_ready) begin
        taken.pos = key_position;
        taken.press = is_press;
        expected_reports.push_back(merge_and_count(taken));
      end
      if (!in_valid || in_ready) begin
        if (in_wait != 0) begin
          in_valid <= 0;
          in_wait <= in_wait - 1;
        end else if (key_events.size() != 0) begin
          ev = key_events.pop_front();
          key_position <= ev.pos;
          is_press <= ev.press;
          in_valid <= 1;
          in_wait <= draw_pause(calm_in);
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  // output side
  always @(posedge clk) begin
    key_report_t want;
    int s;
    if (rst) begin
      out_ready <= 0;
      out_hold <= 0;
    end else if (out_valid && out_ready) begin
      if (expected_reports.size() == 0) begin
        bad_count++;
        if (bad_count <= 10)
          $display("unexpected word: consumed=%0b merged=%0d overflow=%0b",
                   consumed, mapped_position, registry_overflow);
      end else begin
        want = expected_reports.pop_front();
        if (want.consumed !== consumed || want.merged !== mapped_position ||
            want.overflow !== registry_overflow) begin
          bad_count++;
          if (bad_count <= 10)
            $display("word mismatch: expected consumed=%0b merged=%0d overflow=%0b, got %0b %0d %0b",
                     want.consumed, want.merged, want.overflow,
                     consumed, mapped_position, registry_overflow);
        end
      end
      s = draw_pause(calm_out);
      out_ready <= (s == 0);
      out_hold <= s;
    end else if (!out_ready) begin
      if (out_hold <= 1) out_ready <= 1;
      out_hold <= (out_hold > 0) ? out_hold - 1 : 0;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic wait_drained();
    do @(negedge clk);
    while (key_events.size() != 0 || in_valid || expected_reports.size() != 0);
  endtask

  task automatic write_reg(logic [CIDX_W-1:0] idx, logic [WORD_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 0;
    if (idx == REG_PAIR_COUNT) pairs_in_use = data[PC_W-1:0];
    else pair_map[idx - REG_PAIR_WORD0] = data;
  endtask

  task automatic load_pairs(logic [PC_W-1:0] pc, logic [WORD_W-1:0] words [MAP_PAIRS]);
    wait_drained();
    for (int k = 0; k < MAP_PAIRS; k++)
      write_reg(REG_PAIR_WORD0 + CIDX_W'(k), words[k]);
    write_reg(REG_PAIR_COUNT, WORD_W'(pc));
    @(negedge clk);
  endtask

  task automatic push_key(logic [POS_W-1:0] pos, logic press);
    key_event_t ev;
    ev.pos = pos;
    ev.press = press;
    key_events.push_back(ev);
  endtask

  task automatic random_phase(logic [PC_W-1:0] pc, int n);
    logic [POS_W-1:0] pool [8];
    logic [WORD_W-1:0] words [MAP_PAIRS];
    foreach (pool[k]) pool[k] = POS_W'($urandom_range(0, 255));
    foreach (words[k]) words[k] = {pool[$urandom_range(0, 7)], pool[$urandom_range(0, 7)]};
    load_pairs(pc, words);
    repeat (n) begin
      if ($urandom_range(0, 4) == 0) push_key(POS_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      else push_key(pool[$urandom_range(0, 7)], 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    logic [WORD_W-1:0] chain [MAP_PAIRS];
    logic [WORD_W-1:0] hold_pair [MAP_PAIRS];
    foreach (pair_map[k]) pair_map[k] = '0;
    foreach (held[k]) begin
      held[k] = 0;
      held_pos[k] = '0;
      held_count[k] = '0;
    end
    chain = '{16'h0A14, 16'h141E, 16'h00FF, 16'hFF00, 16'h2828, 16'h321E};
    hold_pair = '{16'h0709, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000};

    repeat (2) @(posedge clk);
    rst <= 0;
    @(negedge clk);

    // merging off after reset
    push_key(8'd0, 1);
    push_key(8'd255, 0);
    push_key(8'd255, 1);
    push_key(8'd0, 0);

    // chained pairs and a self pair, all six in use
    load_pairs(3'd6, chain);
    push_key(8'd10, 1);
    push_key(8'd50, 1);
    push_key(8'd30, 1);
    push_key(8'd20, 0);
    push_key(8'd10, 0);
    push_key(8'd30, 0);
    push_key(8'd30, 0);
    push_key(8'd0, 1);
    push_key(8'd255, 1);
    push_key(8'd0, 0);
    push_key(8'd255, 0);
    push_key(8'd40, 1);
    push_key(8'd40, 0);
    push_key(8'd99, 1);
    push_key(8'd99, 0);

    // count above the pair limit
    wait_drained();
    write_reg(REG_PAIR_COUNT, WORD_W'(7));
    @(negedge clk);
    push_key(8'd50, 1);
    push_key(8'd50, 0);

    wait_drained();
    write_reg(REG_PAIR_COUNT, WORD_W'(1));
    @(negedge clk);
    push_key(8'd20, 1);
    push_key(8'd10, 1);
    push_key(8'd10, 0);
    push_key(8'd20, 0);
    push_key(8'd30, 1);

    random_phase(3'd6, 280);
    random_phase(3'd7, 280);
    random_phase(3'd0, 200);
    random_phase(3'd1, 280);
    random_phase(PC_W'($urandom_range(2, 5)), 280);
    random_phase(PC_W'($urandom_range(0, 7)), 280);

    // long hold to reach count saturation
    load_pairs(3'd1, hold_pair);
    repeat (260) push_key($urandom_range(0, 1) ? 8'd7 : 8'd9, 1);
    repeat (5) push_key($urandom_range(0, 1) ? 8'd7 : 8'd9, 0);

    random_phase(3'd6, 200);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    if (bad_count == 0 && expected_reports.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[key_merge_press_counter.f]
+incdir+sv
sv/kmpc_pkg.sv
sv/kmpc_ram.sv
sv/key_merge_press_counter.sv
tb/sv/key_merge_press_counter_tb.sv
